FILE: hw/rtl/bmp_rle4_decoder_macros.svh
// assertion helpers shared by the checker
`ifndef BMP_RLE4_DECODER_MACROS_SVH
`define BMP_RLE4_DECODER_MACROS_SVH

// condition implies consequence in the same cycle
`define RLE4D_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("rle4d check failed");

// condition implies consequence in the next cycle
`define RLE4D_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("rle4d check failed");

`endif

FILE: hw/rtl/rle4d_pkg.sv
`default_nettype none
package rle4d_pkg;

  localparam int POS_W      = 20;
  localparam int CNT_W      = $clog2(POS_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int PROD_W     = 8 + CFG_DATA_W;

  localparam logic [POS_W-1:0]      POS_MAX     = 20'hFFFFF;
  localparam logic [CFG_DATA_W-1:0] MAX_WIDTH   = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] MAX_HEIGHT  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST   = 11'd320;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST  = 11'd240;
  localparam logic [CNT_W-1:0]      MOD_LAST    = CNT_W'(POS_W - 1);
  localparam logic [7:0]            HI_MASK     = 8'hF0;
  localparam logic [7:0]            LO_MASK     = 8'h0F;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // escape codes following a zero command byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PH_CMD    = 3'd0,
    PH_RUNVAL = 3'd1,
    PH_ESC    = 3'd2,
    PH_DX     = 3'd3,
    PH_DY     = 3'd4,
    PH_ABS    = 3'd5,
    PH_PAD    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_EXEC  = 3'd1,
    ST_MUL   = 3'd2,
    ST_DYADD = 3'd3,
    ST_MOD   = 3'd4,
    ST_EOL   = 3'd5
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pixel_offset;
    logic [7:0]       run_length;
    logic [3:0]       first_index;
    logic [3:0]       second_index;
    logic             end_of_bitmap;
    logic             overflow_error;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul;
    logic dy_add;
    logic mod_step;
    logic eol_add;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic eol;
    logic dy;
    logic mod_last;
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rle4d_ctrl.sv
`default_nettype none
module rle4d_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rle4d_pkg::dp_status_t  st,
  output rle4d_pkg::dp_cmd_t     cmd
);

  rle4d_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rle4d_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rle4d_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rle4d_pkg::ST_EXEC;
      end
      rle4d_pkg::ST_EXEC: begin
        // hold while the result register is still occupied
        if (!(st.emit && st.out_full)) begin
          if (st.eol) state_nxt = rle4d_pkg::ST_MOD;
          else if (st.dy) state_nxt = rle4d_pkg::ST_MUL;
          else state_nxt = rle4d_pkg::ST_IDLE;
        end
      end
      rle4d_pkg::ST_MUL: begin
        state_nxt = rle4d_pkg::ST_DYADD;
      end
      rle4d_pkg::ST_DYADD: begin
        state_nxt = rle4d_pkg::ST_IDLE;
      end
      rle4d_pkg::ST_MOD: begin
        if (st.mod_last) state_nxt = rle4d_pkg::ST_EOL;
      end
      rle4d_pkg::ST_EOL: begin
        state_nxt = rle4d_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rle4d_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      rle4d_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      rle4d_pkg::ST_EXEC: begin
        cmd.exec = !(st.emit && st.out_full);
      end
      rle4d_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      rle4d_pkg::ST_DYADD: begin
        cmd.dy_add = 1'b1;
      end
      rle4d_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      rle4d_pkg::ST_EOL: begin
        cmd.eol_add = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rle4d_dpath.sv
`default_nettype none
module rle4d_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rle4d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rle4d_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  rle4d_pkg::in_item_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output rle4d_pkg::out_item_t                  out_data,
  input  rle4d_pkg::dp_cmd_t                    cmd,
  output rle4d_pkg::dp_status_t                 st
);

  localparam int PW = rle4d_pkg::POS_W;
  localparam int DW = rle4d_pkg::CFG_DATA_W;

  // configuration
  logic [DW-1:0] width_r, height_r;
  logic [DW-1:0] ew, eh;

  // parse state
  rle4d_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [7:0]    abs_r, abs_nxt;
  logic          pad_r, pad_nxt;
  logic [7:0]    dcol_r, dcol_nxt;
  logic          fin_r, fin_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  // item payload and arithmetic
  logic [7:0]                   byte_r;
  logic [PW-1:0]                lim_r;
  logic [rle4d_pkg::PROD_W-1:0] prod_r;
  logic [2*DW-1:0]              prod;
  logic [DW-1:0]                mul_b;
  logic [PW-1:0]                lim_nxt;

  // remainder unit
  logic [PW-1:0]                div_r;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [DW:0]                  rem_shift;
  logic [rle4d_pkg::CNT_W-1:0]  cnt_r;

  logic                  out_valid_r;
  rle4d_pkg::out_item_t  out_r, item;

  logic [3:0]    hi, lo, run_hi, run_lo;
  logic [7:0]    run_len;
  logic          emit, is_eob, eol, dy;
  logic [8:0]    abs_sum;
  logic [PW:0]   run_end, dy_tgt, eol_tgt, pos_tgt;
  logic          run_over;

  always_comb begin
    if (width_r == '0) ew = DW'(1);
    else if (width_r > rle4d_pkg::MAX_WIDTH) ew = rle4d_pkg::MAX_WIDTH;
    else ew = width_r;
    if (height_r == '0) eh = DW'(1);
    else if (height_r > rle4d_pkg::MAX_HEIGHT) eh = rle4d_pkg::MAX_HEIGHT;
    else eh = height_r;
  end

  // one shared multiplier: limit at accept, row step for a delta
  assign mul_b   = cmd.mul ? DW'(byte_r) : eh;
  assign prod    = (2*DW)'(ew) * (2*DW)'(mul_b);
  assign lim_nxt = (prod > (2*DW)'(rle4d_pkg::POS_MAX)) ? rle4d_pkg::POS_MAX : prod[PW-1:0];

  assign hi      = 4'((byte_r & rle4d_pkg::HI_MASK) >> 4);
  assign lo      = 4'(byte_r & rle4d_pkg::LO_MASK);
  assign abs_sum = {1'b0, byte_r} + 9'd1;

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    abs_nxt   = abs_r;
    pad_nxt   = pad_r;
    dcol_nxt  = dcol_r;
    fin_nxt   = fin_r;
    emit      = 1'b0;
    is_eob    = 1'b0;
    eol       = 1'b0;
    dy        = 1'b0;
    run_len   = 8'd0;
    run_hi    = hi;
    run_lo    = lo;
    if (!fin_r) begin
      case (phase_r)
        rle4d_pkg::PH_RUNVAL: begin
          emit      = 1'b1;
          run_len   = pend_r;
          phase_nxt = rle4d_pkg::PH_CMD;
        end
        rle4d_pkg::PH_ESC: begin
          phase_nxt = rle4d_pkg::PH_CMD;
          case (byte_r)
            rle4d_pkg::ESC_EOL: begin
              eol = 1'b1;
            end
            rle4d_pkg::ESC_EOB: begin
              emit    = 1'b1;
              is_eob  = 1'b1;
              fin_nxt = 1'b1;
              run_hi  = 4'd0;
              run_lo  = 4'd0;
            end
            rle4d_pkg::ESC_DELTA: begin
              phase_nxt = rle4d_pkg::PH_DX;
            end
            default: begin
              // absolute data: pad when the byte count ceil(n/2) is odd
              abs_nxt   = byte_r;
              pad_nxt   = abs_sum[1];
              phase_nxt = rle4d_pkg::PH_ABS;
            end
          endcase
        end
        rle4d_pkg::PH_DX: begin
          dcol_nxt  = byte_r;
          phase_nxt = rle4d_pkg::PH_DY;
        end
        rle4d_pkg::PH_DY: begin
          dy        = 1'b1;
          phase_nxt = rle4d_pkg::PH_CMD;
        end
        rle4d_pkg::PH_ABS: begin
          emit = 1'b1;
          if (abs_r >= 8'd2) begin
            run_len = 8'd2;
          end else begin
            run_len = abs_r;
            run_lo  = 4'd0;
          end
          abs_nxt = abs_r - run_len;
          if (abs_nxt == 8'd0) begin
            phase_nxt = pad_r ? rle4d_pkg::PH_PAD : rle4d_pkg::PH_CMD;
          end
        end
        rle4d_pkg::PH_PAD: begin
          phase_nxt = rle4d_pkg::PH_CMD;
        end
        default: begin
          if (byte_r == 8'd0) begin
            phase_nxt = rle4d_pkg::PH_ESC;
          end else begin
            pend_nxt  = byte_r;
            phase_nxt = rle4d_pkg::PH_RUNVAL;
          end
        end
      endcase
    end
  end

  assign run_end  = {1'b0, pos_r} + (PW+1)'(run_len);
  assign run_over = run_end > {1'b0, lim_r};
  assign dy_tgt   = {1'b0, pos_r} + (PW+1)'(dcol_r) + (PW+1)'(prod_r);
  assign eol_tgt  = {1'b0, pos_r} + (PW+1)'(ew - rem_r);

  always_comb begin
    item.pixel_offset   = pos_r;
    item.run_length     = run_len;
    item.first_index    = run_hi;
    item.second_index   = run_lo;
    item.end_of_bitmap  = is_eob;
    item.overflow_error = is_eob ? 1'b0 : run_over;
  end

  // every move of the position stops at the pixel limit
  always_comb begin
    if (cmd.dy_add) pos_tgt = dy_tgt;
    else if (cmd.eol_add) pos_tgt = eol_tgt;
    else pos_tgt = run_end;
    pos_nxt = (pos_tgt > {1'b0, lim_r}) ? lim_r : pos_tgt[PW-1:0];
  end

  // restoring remainder, one dividend bit a cycle
  assign rem_shift = {rem_r, div_r[PW-1]};
  always_comb begin
    if (rem_shift >= {1'b0, ew}) rem_nxt = DW'(rem_shift - {1'b0, ew});
    else rem_nxt = rem_shift[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rle4d_pkg::WIDTH_RST;
      height_r <= rle4d_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rle4d_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        rle4d_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: begin
          width_r <= width_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rle4d_pkg::PH_CMD;
      pend_r  <= 8'd0;
      abs_r   <= 8'd0;
      pad_r   <= 1'b0;
      dcol_r  <= 8'd0;
      fin_r   <= 1'b0;
      pos_r   <= '0;
    end else if (cmd.latch) begin
      if (in_data.frame_start) begin
        phase_r <= rle4d_pkg::PH_CMD;
        pend_r  <= 8'd0;
        abs_r   <= 8'd0;
        pad_r   <= 1'b0;
        dcol_r  <= 8'd0;
        fin_r   <= 1'b0;
        pos_r   <= '0;
      end
    end else if (cmd.exec) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      abs_r   <= abs_nxt;
      pad_r   <= pad_nxt;
      dcol_r  <= dcol_nxt;
      fin_r   <= fin_nxt;
      if (emit && !is_eob) pos_r <= pos_nxt;
    end else if (cmd.dy_add) begin
      pos_r <= pos_nxt;
    end else if (cmd.eol_add) begin
      if (rem_r != '0) pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_r <= in_data.data_byte;
      lim_r  <= lim_nxt;
    end
    if (cmd.mul) prod_r <= prod[rle4d_pkg::PROD_W-1:0];
    if (cmd.exec) begin
      div_r <= pos_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.mod_step) begin
      div_r <= div_r << 1;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && emit) out_r <= item;
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  assign st.emit     = emit;
  assign st.eol      = eol;
  assign st.dy       = dy;
  assign st.mod_last = (cnt_r == rle4d_pkg::MOD_LAST);
  assign st.out_full = out_valid_r && !out_ready;

endmodule
`default_nettype wire

FILE: hw/rtl/bmp_rle4_decoder.sv
// 4-bit BMP RLE decoder: one compressed byte per input transfer, at most one
// pixel-run item per byte on the output channel.
// Input channel in_valid/in_ready/in_data carries data_byte and frame_start;
// frame_start clears the parse state and position before the byte is parsed.
// Output channel out_valid/out_ready/out_data carries pixel_offset,
// run_length, two alternating palette indices and the end-of-bitmap and
// overflow flags. cfg_we/cfg_index/cfg_data write image_width (0) and
// image_height (1); write them only while no byte is in flight.
// Timing: a byte passes through accept and execute; a result shows up in the
// cycle after execute. A delta row byte adds a multiply and a row-add step
// (the row step goes through the shared 11-bit multiplier); an end-of-line
// escape adds the 20-step remainder unit and an end-of-line step.
// The result sits in an output register: a new byte is taken while it waits,
// but a byte that makes another result holds in execute until it is taken.
// Reset (rst_n low, synchronous) restores width 320 and height 240, clears
// the position and parse state and empties the output register.
`default_nettype none
module bmp_rle4_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rle4d_pkg::in_item_t                in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rle4d_pkg::out_item_t               out_data,
  input  logic                               cfg_we,
  input  logic [rle4d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rle4d_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rle4d_pkg::dp_cmd_t    cmd;
  rle4d_pkg::dp_status_t st;

  rle4d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rle4d_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/rle4d_chk.sv
`default_nettype none
`include "bmp_rle4_decoder_macros.svh"
module rle4d_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input rle4d_pkg::out_item_t out_data
);

  // a stalled result holds
  `RLE4D_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // every byte goes to execute after its transfer, with in_ready low there
  `RLE4D_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready)

  // end-of-bitmap item carries no pixels and no flags beside its own
  `RLE4D_ASSERT_SAME(a_eob_item, clk, rst_n, out_valid && out_data.end_of_bitmap, out_data.run_length == 8'd0 && out_data.first_index == 4'd0 && out_data.second_index == 4'd0 && !out_data.overflow_error)

  // a new result only follows an execute cycle
  `RLE4D_ASSERT_SAME(a_out_after_exec, clk, rst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind bmp_rle4_decoder rle4d_chk u_chk (.*);
`default_nettype wire
